/* design/two_wire_bitbang_byte_responder_core_macros.svh */
// Assertion macros used by the two-wire byte responder core.
`ifndef TWO_WIRE_BITBANG_BYTE_RESPONDER_CORE_MACROS_SVH
`define TWO_WIRE_BITBANG_BYTE_RESPONDER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BBR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BBR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bbr_pkg.sv */
// Package with the types and constants of the two-wire byte responder.
`timescale 1ns / 1ps

package bbr_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned COUNT_W    = 4;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 16;

	typedef enum logic {
		CMD_POLL  = 1'b0,
		CMD_START = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		PH_RAISE     = 2'd0,
		PH_WAIT_HIGH = 2'd1,
		PH_WAIT_LOW  = 2'd2
	} phase_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              start_read;
		logic [BYTE_W-1:0] write_byte;
		logic              pin_a;
		logic              pin_b;
	} item_t;

	typedef struct packed {
		logic               bootstrapping;
		logic               boot_stage;
		logic               clock_is_b;
		logic               reading;
		logic [BYTE_W-1:0]  shift_reg;
		phase_t             bit_phase;
		logic [COUNT_W-1:0] bits_done;
		logic               drive_a;
		logic               drive_b;
	} state_t;

	typedef struct packed {
		logic              drive_a;
		logic              drive_b;
		logic              byte_done;
		logic [BYTE_W-1:0] read_byte;
		logic              clock_on_b;
		logic              in_bootstrap;
	} result_t;

	localparam state_t STATE_RESET = '{
		bootstrapping: 1'b1,
		boot_stage:    1'b0,
		clock_is_b:    1'b0,
		reading:       1'b0,
		shift_reg:     '0,
		bit_phase:     PH_RAISE,
		bits_done:     COUNT_W'(BYTE_W),
		drive_a:       1'b1,
		drive_b:       1'b1
	};

endpackage

/* design/two_wire_bitbang_byte_responder_core.sv */
// Top level of the two-wire bit-banged byte responder with stream ports.
// An accepted item enters the input register; its result leaves from the result register.
// Throughput: one item per cycle unless stalled; the state update is combinational.
// A stalled master side holds the result register and backs up into the input register.
// Asynchronous reset releases both wires, restarts clock detection and empties the registers.
`timescale 1ns / 1ps
`include "two_wire_bitbang_byte_responder_core_macros.svh"

module two_wire_bitbang_byte_responder_core
	import bbr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// Fields from bit 0: start_read, write_byte[7:0], pin_a, pin_b, zero fill.
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// Fields from bit 0: cmd.
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// Fields from bit 0: drive_a, drive_b, byte_done, read_byte[7:0],
	// clock_on_b, in_bootstrap, zero fill.
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	state_t  st_q;
	state_t  st_next;
	result_t res_next;
	logic    advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd        <= cmd_t'(s_tuser);
			item_s1.start_read <= s_tdata[0];
			item_s1.write_byte <= s_tdata[BYTE_W:1];
			item_s1.pin_a      <= s_tdata[BYTE_W+1];
			item_s1.pin_b      <= s_tdata[BYTE_W+2];
		end
	end

	bbr_step u_step (
		.item (item_s1),
		.cur  (st_q),
		.nxt  (st_next),
		.res  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2.in_bootstrap, res_s2.clock_on_b, res_s2.read_byte,
		res_s2.byte_done, res_s2.drive_b, res_s2.drive_a};

	`BBR_ASSERT_NOW(a_boot_stage_kept, !st_q.bootstrapping, st_q.boot_stage,
		"Clock chosen before bootstrap release.")
	`BBR_ASSERT_NOW(a_count_in_range, st_q.bits_done[COUNT_W-1],
		st_q.bits_done[COUNT_W-2:0] == '0, "Bit count past one byte.")
	`BBR_ASSERT_NEXT(a_start_not_done, advance && item_s1.cmd == CMD_START,
		!res_s2.byte_done && st_q.bits_done == '0, "Start item reported as done.")

endmodule

/* design/bbr_step.sv */
// Next-state and result logic for one item of the two-wire byte responder.
`timescale 1ns / 1ps

module bbr_step
	import bbr_pkg::*;
(
	input  item_t   item,
	input  state_t  cur,
	output state_t  nxt,
	output result_t res
);

	logic clk_b;
	logic clk_level;
	logic dat_level;
	logic run;
	logic done;
	logic [COUNT_W-1:0] count_inc;

	always_comb begin
		nxt       = cur;
		done      = 1'b0;
		run       = 1'b0;
		clk_b     = cur.clock_is_b;
		count_inc = cur.bits_done + COUNT_W'(1);
		if (item.cmd == CMD_START) begin
			nxt.reading   = item.start_read;
			nxt.shift_reg = item.start_read ? '0 : item.write_byte;
			nxt.bit_phase = PH_RAISE;
			nxt.bits_done = '0;
		end else if (cur.bootstrapping) begin
			if (!cur.boot_stage) begin
				nxt.drive_a    = 1'b1;
				nxt.drive_b    = 1'b1;
				nxt.boot_stage = 1'b1;
			end else if (!item.pin_a) begin
				clk_b             = 1'b0;
				nxt.clock_is_b    = 1'b0;
				nxt.bootstrapping = 1'b0;
				run               = 1'b1;
			end else if (!item.pin_b) begin
				clk_b             = 1'b1;
				nxt.clock_is_b    = 1'b1;
				nxt.bootstrapping = 1'b0;
				run               = 1'b1;
			end
		end else begin
			run = 1'b1;
		end

		clk_level = clk_b ? item.pin_b : item.pin_a;
		dat_level = clk_b ? item.pin_a : item.pin_b;

		if (run) begin
			if (cur.bits_done[COUNT_W-1]) begin
				done = 1'b1;
			end else begin
				case (cur.bit_phase)
					PH_RAISE: begin
						if (clk_b) nxt.drive_b = 1'b1;
						else nxt.drive_a = 1'b1;
						nxt.bit_phase = PH_WAIT_HIGH;
					end
					PH_WAIT_HIGH: begin
						if (clk_level) begin
							if (cur.reading) begin
								if (clk_b) nxt.drive_a = 1'b1;
								else nxt.drive_b = 1'b1;
							end
							nxt.bit_phase = PH_WAIT_LOW;
						end
					end
					PH_WAIT_LOW: begin
						if (!clk_level) begin
							if (cur.reading) begin
								nxt.shift_reg = {cur.shift_reg[BYTE_W-2:0], dat_level};
							end else if (clk_b) begin
								nxt.drive_a = cur.shift_reg[~cur.bits_done[COUNT_W-2:0]];
							end else begin
								nxt.drive_b = cur.shift_reg[~cur.bits_done[COUNT_W-2:0]];
							end
							nxt.bits_done = count_inc;
							nxt.bit_phase = PH_RAISE;
							if (count_inc[COUNT_W-1]) begin
								if (clk_b) nxt.drive_b = 1'b0;
								else nxt.drive_a = 1'b0;
								done = 1'b1;
							end
						end
					end
					default: begin
						done = 1'b0;
					end
				endcase
			end
		end

		res.drive_a      = nxt.drive_a;
		res.drive_b      = nxt.drive_b;
		res.byte_done    = done;
		res.read_byte    = nxt.shift_reg;
		res.clock_on_b   = nxt.clock_is_b;
		res.in_bootstrap = nxt.bootstrapping;
	end

endmodule
